[rtl/eegfp_pkg.sv]
// Package for the EEG headset frame parser: header byte values, frame positions
// and the header match function. Depends on nothing; used by
// eeg_headset_frame_parser_core, the frame monitor and the testbench.
`default_nettype none

package eegfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 6;

  localparam logic [ByteW-1:0] SyncByte    = 8'hAA;
  localparam logic [ByteW-1:0] HdrLenByte  = 8'h20;
  localparam logic [ByteW-1:0] HdrCodeByte = 8'h02;
  localparam logic [ByteW-1:0] HdrAsicByte = 8'h83;
  localparam logic [ByteW-1:0] HdrSizeByte = 8'h18;

  localparam logic [PosW-1:0] PosSync0   = 6'd0;
  localparam logic [PosW-1:0] PosSync1   = 6'd1;
  localparam logic [PosW-1:0] PosLen     = 6'd2;
  localparam logic [PosW-1:0] PosCode    = 6'd3;
  localparam logic [PosW-1:0] PosAsic    = 6'd5;
  localparam logic [PosW-1:0] PosSize    = 6'd6;
  localparam logic [PosW-1:0] PosSumFrst = 6'd3;
  localparam logic [PosW-1:0] PosAtt     = 6'd32;
  localparam logic [PosW-1:0] PosMed     = 6'd34;
  localparam logic [PosW-1:0] PosCheck   = 6'd35;

  typedef struct packed {
    logic             checksum_ok;
    logic [ByteW-1:0] attention;
    logic [ByteW-1:0] meditation;
  } result_t;

  // True when the byte is acceptable at the given position of the header.
  // Positions past the header and position 4, which is not checked, accept any byte.
  function automatic logic hdr_match(logic [PosW-1:0] pos, logic [ByteW-1:0] b);
    logic m;
    case (pos)
      PosSync0: m = (b == SyncByte);
      PosSync1: m = (b == SyncByte);
      PosLen:   m = (b == HdrLenByte);
      PosCode:  m = (b == HdrCodeByte);
      PosAsic:  m = (b == HdrAsicByte);
      PosSize:  m = (b == HdrSizeByte);
      default:  m = 1'b1;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/eeg_headset_frame_parser_core.sv]
// Top level of the EEG headset frame parser: byte input register, frame state,
// header check, checksum and result register. Depends on eegfp_pkg.
//
//   channel | signals                          | direction | carries
//   --------+----------------------------------+-----------+------------------------------
//   in      | in_valid_i, in_stall_o, rx_byte_i | into core | one received serial word
//   out     | out_valid_o, out_stall_i,         | out       | checksum verdict and held
//           | checksum_ok_o, attention_o,       |           | attention / meditation
//           | meditation_o                      |           |
//
// Each word is taken into an input register and examined there against the frame
// state; a closing word writes the result register. One word is accepted every cycle
// while the result register is free, that is while it holds no stalled result.
// The result register is the only stall point: a held result stalls the examine step,
// and a word waiting there stalls the input. Reset clears frame position, sum and the
// held values to zero and empties both registers.
`default_nettype none

module eeg_headset_frame_parser_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            checksum_ok_o,
  output logic [7:0]      attention_o,
  output logic [7:0]      meditation_o
);

  logic                            in_valid_q;
  logic [eegfp_pkg::ByteW-1:0]     in_byte_q;
  logic [eegfp_pkg::PosW-1:0]      pos_q, pos_d;
  logic [eegfp_pkg::ByteW-1:0]     sum_q, sum_d;
  logic [eegfp_pkg::ByteW-1:0]     pend_att_q, pend_att_d;
  logic [eegfp_pkg::ByteW-1:0]     pend_med_q, pend_med_d;
  logic [eegfp_pkg::ByteW-1:0]     held_att_q, held_att_d;
  logic [eegfp_pkg::ByteW-1:0]     held_med_q, held_med_d;
  logic                            out_valid_q, out_valid_d;
  eegfp_pkg::result_t              res_q, res_d;

  logic out_free;
  logic fire;
  logic in_accept;
  logic pos_ok;
  logic frame_end;
  logic sum_good;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign pos_ok    = (pos_q <= eegfp_pkg::PosCheck) &&
                     eegfp_pkg::hdr_match(pos_q, in_byte_q);
  assign frame_end = fire && pos_ok && (pos_q == eegfp_pkg::PosCheck);
  assign sum_good  = (~sum_q == in_byte_q);

  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    pend_att_d  = pend_att_q;
    pend_med_d  = pend_med_q;
    held_att_d  = held_att_q;
    held_med_d  = held_med_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      if (!pos_ok) begin
        // A bad header word drops the frame; it is not retried as a sync word.
        pos_d = '0;
        sum_d = '0;
      end else if (pos_q == eegfp_pkg::PosCheck) begin
        if (sum_good) begin
          held_att_d = pend_att_q;
          held_med_d = pend_med_q;
        end
        res_d.checksum_ok = sum_good;
        res_d.attention   = sum_good ? pend_att_q : held_att_q;
        res_d.meditation  = sum_good ? pend_med_q : held_med_q;
        out_valid_d       = 1'b1;
        pos_d             = '0;
        sum_d             = '0;
      end else begin
        if (pos_q >= eegfp_pkg::PosSumFrst) begin
          sum_d = sum_q + in_byte_q;
        end
        if (pos_q == eegfp_pkg::PosAtt) begin
          pend_att_d = in_byte_q;
        end
        if (pos_q == eegfp_pkg::PosMed) begin
          pend_med_d = in_byte_q;
        end
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      sum_q       <= '0;
      pend_att_q  <= '0;
      pend_med_q  <= '0;
      held_att_q  <= '0;
      held_med_q  <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      pend_att_q  <= pend_att_d;
      pend_med_q  <= pend_med_d;
      held_att_q  <= held_att_d;
      held_med_q  <= held_med_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
    res_q <= res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign checksum_ok_o = res_q.checksum_ok;
  assign attention_o   = res_q.attention;
  assign meditation_o  = res_q.meditation;

  // The frame position never leaves the 36-byte frame.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= eegfp_pkg::PosCheck)
    else $error("frame position out of range");

  // A shown result always carries the currently held values.
  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (attention_o == held_att_q) && (meditation_o == held_med_q))
    else $error("result differs from held values");

  // A closed frame restarts position and sum.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> (pos_q == '0) && (sum_q == '0) && out_valid_q)
    else $error("frame did not restart after its check word");

  // The input is stalled only while a word waits in the input register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled without a waiting word");

endmodule

`default_nettype wire

[verif/eeg_headset_frame_parser_monitor.sv]
`timescale 1ns / 1ps
// Frame monitor for the EEG headset frame parser testbench: follows every accepted
// word, predicts the frame verdicts and compares them with the block's results.
// Depends on eegfp_pkg for the header values, frame positions and result type.

module eeg_headset_frame_parser_monitor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [eegfp_pkg::ByteW-1:0] rx_byte_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        checksum_ok_i,
  input  logic [eegfp_pkg::ByteW-1:0] attention_i,
  input  logic [eegfp_pkg::ByteW-1:0] meditation_i,
  output int                          error_count_o,
  output int                          awaited_count_o
);

  typedef logic [eegfp_pkg::ByteW-1:0] word_t;
  typedef logic [eegfp_pkg::PosW-1:0]  pos_t;

  pos_t               frame_pos;
  word_t              frame_sum;
  word_t              att_pending;
  word_t              med_pending;
  word_t              att_held;
  word_t              med_held;
  eegfp_pkg::result_t frame_verdicts[$];
  int                 fails;

  function automatic logic header_word_fits(pos_t pos, word_t b);
    logic fits;
    fits = 1'b1;
    if (pos == eegfp_pkg::PosSync0 || pos == eegfp_pkg::PosSync1) begin
      fits = (b == eegfp_pkg::SyncByte);
    end else if (pos == eegfp_pkg::PosLen)  fits = (b == eegfp_pkg::HdrLenByte);
    else if (pos == eegfp_pkg::PosCode) fits = (b == eegfp_pkg::HdrCodeByte);
    else if (pos == eegfp_pkg::PosAsic) fits = (b == eegfp_pkg::HdrAsicByte);
    else if (pos == eegfp_pkg::PosSize) fits = (b == eegfp_pkg::HdrSizeByte);
    return fits;
  endfunction

  // Advances the frame state by one word and queues a verdict when the frame closes.
  task automatic parse_word(input word_t b);
    eegfp_pkg::result_t verdict;
    word_t              inv_sum;
    if (frame_pos > eegfp_pkg::PosCheck || !header_word_fits(frame_pos, b)) begin
      frame_pos = '0;
      frame_sum = '0;
    end else if (frame_pos == eegfp_pkg::PosCheck) begin
      inv_sum = ~frame_sum;
      verdict.checksum_ok = (inv_sum == b);
      if (verdict.checksum_ok) begin
        att_held = att_pending;
        med_held = med_pending;
      end
      verdict.attention  = att_held;
      verdict.meditation = med_held;
      frame_verdicts.push_back(verdict);
      frame_pos = '0;
      frame_sum = '0;
    end else begin
      if (frame_pos >= eegfp_pkg::PosSumFrst) frame_sum = frame_sum + b;
      if (frame_pos == eegfp_pkg::PosAtt) att_pending = b;
      if (frame_pos == eegfp_pkg::PosMed) med_pending = b;
      frame_pos = frame_pos + 1'b1;
    end
  endtask

  task automatic compare_field(input string name, input word_t want, input word_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    eegfp_pkg::result_t want;
    if (!rst_ni) begin
      frame_pos   = '0;
      frame_sum   = '0;
      att_pending = '0;
      med_pending = '0;
      att_held    = '0;
      med_held    = '0;
      frame_verdicts.delete();
      fails = 0;
      error_count_o   <= 0;
      awaited_count_o <= 0;
    end else begin
      // Results are checked before the word of this edge is parsed, so an early
      // result can never match a verdict that is only now being predicted.
      if (out_valid_i && !out_stall_i) begin
        if (frame_verdicts.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual ok=%0b att=%0h med=%0h",
                   $time, checksum_ok_i, attention_i, meditation_i);
          fails++;
        end else begin
          want = frame_verdicts.pop_front();
          compare_field("checksum_ok", word_t'(want.checksum_ok), word_t'(checksum_ok_i));
          compare_field("attention", want.attention, attention_i);
          compare_field("meditation", want.meditation, meditation_i);
        end
      end
      if (in_valid_i && !in_stall_i) parse_word(rx_byte_i);
      error_count_o   <= fails;
      awaited_count_o <= frame_verdicts.size();
    end
  end

endmodule

[verif/eeg_headset_frame_parser_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the EEG headset frame parser: sends header fragments, frames,
// broken headers and stray words with random idling on both sides, gives the verdict.
// Depends on eegfp_pkg, eeg_headset_frame_parser_core and the frame monitor.

module eeg_headset_frame_parser_core_tb;

  typedef logic [eegfp_pkg::ByteW-1:0] word_t;

  localparam int RandWords  = 1800;
  localparam int QuietLimit = 5000;
  localparam int FrameLen   = 36;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  word_t rx_byte;
  logic  out_valid;
  logic  out_stall;
  logic  checksum_ok;
  word_t attention;
  word_t meditation;
  int    error_count;
  int    awaited_count;
  int    send_idle_pct;
  int    recv_stall_pct;
  int    quiet_cycles;

  eeg_headset_frame_parser_core DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .checksum_ok_o(checksum_ok),
    .attention_o  (attention),
    .meditation_o (meditation)
  );

  eeg_headset_frame_parser_monitor frame_monitor (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .checksum_ok_i  (checksum_ok),
    .attention_i    (attention),
    .meditation_i   (meditation),
    .error_count_o  (error_count),
    .awaited_count_o(awaited_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Valid stays high from one word to the next unless the sender decides to idle.
  task automatic send_word(input word_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
  endtask

  function automatic word_t header_word(input int pos);
    word_t w;
    case (pos)
      int'(eegfp_pkg::PosSync0), int'(eegfp_pkg::PosSync1): w = eegfp_pkg::SyncByte;
      int'(eegfp_pkg::PosLen):  w = eegfp_pkg::HdrLenByte;
      int'(eegfp_pkg::PosCode): w = eegfp_pkg::HdrCodeByte;
      int'(eegfp_pkg::PosAsic): w = eegfp_pkg::HdrAsicByte;
      int'(eegfp_pkg::PosSize): w = eegfp_pkg::HdrSizeByte;
      default:                  w = word_t'($urandom_range(255));
    endcase
    return w;
  endfunction

  function automatic word_t edgy_word();
    word_t w;
    case ($urandom_range(3))
      0:       w = 8'h00;
      1:       w = 8'hFF;
      default: w = word_t'($urandom_range(255));
    endcase
    return w;
  endfunction

  task automatic send_frame(input word_t att, input word_t med, input logic bad_sum);
    word_t words[FrameLen];
    word_t sum;
    sum = '0;
    for (int p = 0; p < FrameLen - 1; p++) begin
      if (p <= int'(eegfp_pkg::PosSize)) words[p] = header_word(p);
      else if (p == int'(eegfp_pkg::PosAtt)) words[p] = att;
      else if (p == int'(eegfp_pkg::PosMed)) words[p] = med;
      else words[p] = word_t'($urandom_range(255));
      if (p >= int'(eegfp_pkg::PosSumFrst)) sum = sum + words[p];
    end
    words[eegfp_pkg::PosCheck] = ~sum;
    if (bad_sum) begin
      words[eegfp_pkg::PosCheck] = words[eegfp_pkg::PosCheck] ^
                                   word_t'($urandom_range(1, 255));
    end
    foreach (words[p]) send_word(words[p]);
  endtask

  // Sends a valid header prefix, then a wrong word at one of the checked positions.
  task automatic send_broken_header(output int sent);
    int checked[6] = '{int'(eegfp_pkg::PosSync0), int'(eegfp_pkg::PosSync1),
                       int'(eegfp_pkg::PosLen), int'(eegfp_pkg::PosCode),
                       int'(eegfp_pkg::PosAsic), int'(eegfp_pkg::PosSize)};
    int bad_pos;
    bad_pos = checked[$urandom_range(5)];
    for (int p = 0; p < bad_pos; p++) send_word(header_word(p));
    send_word(header_word(bad_pos) ^ word_t'($urandom_range(1, 255)));
    sent = bad_pos + 1;
  endtask

  initial begin
    word_t fragments[$] = '{
      eegfp_pkg::SyncByte, 8'h55,
      eegfp_pkg::SyncByte, eegfp_pkg::SyncByte, eegfp_pkg::SyncByte,
      eegfp_pkg::SyncByte, eegfp_pkg::SyncByte, 8'h21,
      eegfp_pkg::SyncByte, eegfp_pkg::SyncByte, eegfp_pkg::HdrLenByte, 8'h03,
      eegfp_pkg::SyncByte, eegfp_pkg::SyncByte, eegfp_pkg::HdrLenByte,
      eegfp_pkg::HdrCodeByte, 8'h5A, 8'h82,
      eegfp_pkg::SyncByte, eegfp_pkg::SyncByte, eegfp_pkg::HdrLenByte,
      eegfp_pkg::HdrCodeByte, 8'hA5, eegfp_pkg::HdrAsicByte, 8'h19
    };
    int frame_words;
    int frames_sent;
    int phase;
    int next_phase;
    int kind;
    int sent;
    int extra;

    in_valid       = 1'b0;
    rx_byte        = '0;
    out_stall      = 1'b0;
    rst_n          = 1'b0;
    quiet_cycles   = 0;
    send_idle_pct  = 8;
    recv_stall_pct = 49;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Header fragments, including a third sync word that must be dropped, not reused.
    foreach (fragments[i]) send_word(fragments[i]);
    send_frame(8'hFF, 8'h00, 1'b0);
    send_frame(8'h00, 8'hFF, 1'b1);
    send_frame(8'h00, 8'hFF, 1'b0);
    drain_results();

    frame_words = 0;
    frames_sent = 0;
    phase       = 0;
    while (frame_words < RandWords) begin
      next_phase = (frame_words * 3) / RandWords;
      if (next_phase > 2) next_phase = 2;
      if (next_phase != phase) begin
        phase = next_phase;
        drain_results();
        send_idle_pct  = (phase == 1) ? 49 : 0;
        recv_stall_pct = (phase == 1) ? 8 : 0;
      end
      kind = $urandom_range(99);
      if (kind < 72) begin
        send_frame(edgy_word(), edgy_word(), 1'b0);
        frame_words += FrameLen;
        frames_sent++;
      end else if (kind < 84) begin
        send_frame(edgy_word(), edgy_word(), 1'b1);
        frame_words += FrameLen;
        frames_sent++;
      end else if (kind < 94) begin
        send_broken_header(sent);
        frame_words += sent;
      end else begin
        extra = $urandom_range(1, 4);
        repeat (extra) send_word(word_t'($urandom_range(255)));
        frame_words += extra;
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0 && awaited_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
